[rtl/llp_pkg.sv]
// Shared types, constants and codes for the LL(1) predictive parser.
`timescale 1ns / 1ps
package llp_pkg;

  // Sizes of the grammar tables and the parse stack.
  localparam int NONTERMINALS = 16;
  localparam int TERMINALS    = 16;
  localparam int PROD_LEN     = 8;
  localparam int STACK_DEPTH  = 64;
  localparam int EXP_LIMIT    = 32;
  localparam int COLUMNS      = TERMINALS + 1;
  localparam int ENTRIES      = NONTERMINALS * COLUMNS;

  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int POS_W  = 3;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 4;
  localparam int ENT_W  = 9;
  localparam int SADR_W = ENT_W + POS_W;
  localparam int SP_W   = 7;
  localparam int STK_AW = 6;
  localparam int CNT_W  = 6;

  localparam logic [SYM_W-1:0] END_MARK = 8'h24;
  localparam logic [SYM_W-1:0] EPSILON  = 8'h23;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_NT_WR  = 3'd0,
    OP_T_WR   = 3'd1,
    OP_SYM_WR = 3'd2,
    OP_LEN_WR = 3'd3,
    OP_BEGIN  = 3'd4,
    OP_TOKEN  = 3'd5,
    OP_EOI    = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START    = 2'd0;
  localparam logic [1:0] CFG_NT_COUNT = 2'd1;
  localparam logic [1:0] CFG_T_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE, PH_PARSING, PH_ACCEPTED, PH_REJECTED
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BEGIN, S_EXP, S_LEN, S_CNT, S_PUSH, S_TOPRD, S_TOPWT, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] entry_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] expansions;
    logic [SP_W-1:0]  stack_level;
  } out_item_t;

  // Write requests into the parse table memories.
  typedef struct packed {
    logic              sym_we;
    logic [SADR_W-1:0] sym_addr;
    logic [SYM_W-1:0]  sym_data;
    logic              len_we;
    logic [ENT_W-1:0]  len_addr;
    logic [LEN_W-1:0]  len_data;
  } tbl_wr_t;

endpackage

[rtl/llp_tables.sv]
// Parse table memories: entry lengths with a clearing pass, and entry symbols.
`timescale 1ns / 1ps
module llp_tables
  import llp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tbl_wr_t           wr,
  input  logic [ENT_W-1:0]  len_rd_addr,
  input  logic [SADR_W-1:0] sym_rd_addr,
  output logic [LEN_W-1:0]  len_rd_data,
  output logic [SYM_W-1:0]  sym_rd_data,
  output logic              busy
);

  logic [LEN_W-1:0] len_mem [ENTRIES];
  logic [SYM_W-1:0] sym_mem [ENTRIES*PROD_LEN];
  logic [ENT_W-1:0] clr_r;
  logic             clr_busy_r;

  // Clearing pass after reset: one length entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == ENT_W'(ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Length memory, zeroed by the clearing pass.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      len_mem[clr_r] <= '0;
    end else if (wr.len_we) begin
      len_mem[wr.len_addr] <= wr.len_data;
    end
    len_rd_data <= len_mem[len_rd_addr];
  end

  // Symbol memory.
  always_ff @(posedge clk) begin
    if (wr.sym_we) begin
      sym_mem[wr.sym_addr] <= wr.sym_data;
    end
    sym_rd_data <= sym_mem[sym_rd_addr];
  end

  assign busy = clr_busy_r;

endmodule

[rtl/ll1_predictive_parser_core.sv]
// LL(1) predictive parser: a sequencer over parse table and stack memories.
// A begin writes the end mark and then the start symbol; a token or end of input
// expands the nonterminals on top of the stack through its table column, and a token
// then pops its match, with the table and stack memories read through registered outputs.
// One transaction is worked on at a time; results leave through an output register.
// Reset: synchronous active low; a clearing pass over the 272 entries of the length table follows.
`timescale 1ns / 1ps
module ll1_predictive_parser_core
  import llp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  fsm_t             state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [SYM_W-1:0] top_r, top_nxt;
  logic [SYM_W-1:0] tok_r, tok_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             eoi_r, eoi_nxt;
  logic             ret_fin_r, ret_fin_nxt;
  logic [ENT_W-1:0] e_r, e_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0] pushes_r, pushes_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r;
  logic             out_valid_r;
  logic [7:0]       start_r;
  logic [4:0]       ntc_r, tc_r;
  logic [SYM_W-1:0] nt_list_r [NONTERMINALS];
  logic [SYM_W-1:0] t_list_r [TERMINALS];
  logic [SYM_W-1:0] stk_mem [STACK_DEPTH];
  logic [SYM_W-1:0] stk_rd_r;

  logic              in_acc;
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [SYM_W-1:0]  stk_wdata;
  logic              nt_we, t_we;
  tbl_wr_t           tbl_wr;
  logic [ENT_W-1:0]  len_rd_addr;
  logic [SADR_W-1:0] sym_rd_addr;
  logic [LEN_W-1:0]  len_rd_data;
  logic [SYM_W-1:0]  sym_rd_data;
  logic              tbl_busy;
  logic              row_hit, t_hit;
  logic [ROW_W-1:0]  row_idx;
  logic [COL_W-1:0]  t_idx;
  logic [LEN_W-1:0]  p_sum;
  logic [SP_W:0]     need;

  llp_tables u_tables (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (tbl_wr),
    .len_rd_addr (len_rd_addr),
    .sym_rd_addr (sym_rd_addr),
    .len_rd_data (len_rd_data),
    .sym_rd_data (sym_rd_data),
    .busy        (tbl_busy)
  );

  assign in_ready  = (state_r == S_IDLE) && !tbl_busy;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Classify the top of stack and the token against the symbol lists.
  always_comb begin
    row_hit = 1'b0;
    row_idx = '0;
    t_hit   = 1'b0;
    t_idx   = '0;
    for (int i = 0; i < NONTERMINALS; i++) begin
      if (!row_hit && (5'(i) < ntc_r) && nt_list_r[i] == top_r) begin
        row_hit = 1'b1;
        row_idx = ROW_W'(i);
      end
    end
    for (int i = 0; i < TERMINALS; i++) begin
      if (!t_hit && (5'(i) < tc_r) && t_list_r[i] == in_data.symbol) begin
        t_hit = 1'b1;
        t_idx = COL_W'(i);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'd83;
      ntc_r   <= '0;
      tc_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START:    start_r <= cfg_data;
        CFG_NT_COUNT: ntc_r   <= cfg_data[4:0];
        CFG_T_COUNT:  tc_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Symbol lists, written in place.
  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_list_r[in_data.row_index] <= in_data.symbol;
    end
    if (t_we) begin
      t_list_r[in_data.col_index[3:0]] <= in_data.symbol;
    end
  end

  // Parse stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      sp_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      sp_r    <= sp_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    tok_r     <= tok_nxt;
    col_r     <= col_nxt;
    eoi_r     <= eoi_nxt;
    ret_fin_r <= ret_fin_nxt;
    e_r       <= e_nxt;
    len_r     <= len_nxt;
    k_r       <= k_nxt;
    pushes_r  <= pushes_nxt;
    res_r     <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  // Sequencer: next state and memory accesses.
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    sp_nxt      = sp_r;
    top_nxt     = top_r;
    tok_nxt     = tok_r;
    col_nxt     = col_r;
    eoi_nxt     = eoi_r;
    ret_fin_nxt = ret_fin_r;
    e_nxt       = e_r;
    len_nxt     = len_r;
    k_nxt       = k_r;
    pushes_nxt  = pushes_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    stk_we      = 1'b0;
    stk_waddr   = '0;
    stk_wdata   = END_MARK;
    stk_raddr   = STK_AW'(sp_r - 1'b1);
    nt_we       = 1'b0;
    t_we        = 1'b0;
    tbl_wr      = '0;
    len_rd_addr = e_r;
    sym_rd_addr = {e_r, k_r};
    p_sum       = pushes_r + LEN_W'(sym_rd_data != EPSILON);
    need        = {1'b0, sp_r} - 1'b1 + (SP_W+1)'(p_sum);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_data.operation))
            OP_NT_WR: nt_we = 1'b1;
            OP_T_WR:  t_we  = !in_data.col_index[4];
            OP_SYM_WR: begin
              tbl_wr.sym_we   = (in_data.col_index <= COL_W'(TERMINALS));
              tbl_wr.sym_addr = {ENT_W'({in_data.row_index, 4'b0}) +
                                 ENT_W'(in_data.row_index) +
                                 ENT_W'(in_data.col_index), in_data.position};
              tbl_wr.sym_data = in_data.symbol;
            end
            OP_LEN_WR: begin
              tbl_wr.len_we   = (in_data.col_index <= COL_W'(TERMINALS));
              tbl_wr.len_addr = ENT_W'({in_data.row_index, 4'b0}) +
                                ENT_W'(in_data.row_index) + ENT_W'(in_data.col_index);
              tbl_wr.len_data = (in_data.entry_length > LEN_W'(PROD_LEN)) ?
                                LEN_W'(PROD_LEN) : in_data.entry_length;
            end
            OP_BEGIN: begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = END_MARK;
              state_nxt = S_BEGIN;
            end
            OP_TOKEN, OP_EOI: begin
              count_nxt = '0;
              eoi_nxt   = (op_t'(in_data.operation) == OP_EOI);
              tok_nxt   = in_data.symbol;
              if (phase_r != PH_PARSING) begin
                res_nxt   = '{(phase_r == PH_ACCEPTED) ? ST_ACCEPT : ST_REJECT, '0, sp_r};
                state_nxt = S_DONE;
              end else if (op_t'(in_data.operation) == OP_EOI) begin
                col_nxt   = COL_W'(TERMINALS);
                state_nxt = S_EXP;
              end else if (t_hit) begin
                col_nxt   = t_idx;
                state_nxt = S_EXP;
              end else begin
                phase_nxt = PH_REJECTED;
                res_nxt   = '{ST_REJECT, '0, sp_r};
                state_nxt = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_BEGIN: begin
        stk_we    = 1'b1;
        stk_waddr = STK_AW'(1);
        stk_wdata = start_r;
        top_nxt   = start_r;
        sp_nxt    = SP_W'(2);
        phase_nxt = PH_PARSING;
        state_nxt = S_IDLE;
      end
      S_EXP: begin
        if (sp_r > SP_W'(1) && row_hit) begin
          e_nxt       = ENT_W'({row_idx, 4'b0}) + ENT_W'(row_idx) + ENT_W'(col_r);
          len_rd_addr = e_nxt;
          state_nxt   = S_LEN;
        end else if (eoi_r) begin
          phase_nxt = (sp_r == SP_W'(1)) ? PH_ACCEPTED : PH_REJECTED;
          res_nxt   = '{(sp_r == SP_W'(1)) ? ST_ACCEPT : ST_REJECT, count_r, sp_r};
          state_nxt = S_DONE;
        end else if (sp_r > SP_W'(1) && top_r == tok_r) begin
          sp_nxt      = sp_r - 1'b1;
          ret_fin_nxt = 1'b1;
          state_nxt   = S_TOPRD;
        end else begin
          phase_nxt = PH_REJECTED;
          res_nxt   = '{ST_REJECT, count_r, sp_r};
          state_nxt = S_DONE;
        end
      end
      S_LEN: begin
        if (len_rd_data == '0 || count_r >= CNT_W'(EXP_LIMIT)) begin
          phase_nxt = PH_REJECTED;
          res_nxt   = '{ST_REJECT, count_r, sp_r};
          state_nxt = S_DONE;
        end else begin
          len_nxt     = len_rd_data;
          k_nxt       = '0;
          pushes_nxt  = '0;
          sym_rd_addr = {e_r, POS_W'(0)};
          state_nxt   = S_CNT;
        end
      end
      S_CNT: begin
        // Count the symbols that will really be pushed.
        pushes_nxt = p_sum;
        if (LEN_W'(k_r) == len_r - 1'b1) begin
          if (need > (SP_W+1)'(STACK_DEPTH)) begin
            phase_nxt = PH_REJECTED;
            res_nxt   = '{ST_REJECT, count_r, sp_r};
            state_nxt = S_DONE;
          end else begin
            sp_nxt      = sp_r - 1'b1;
            k_nxt       = POS_W'(len_r - 1'b1);
            sym_rd_addr = {e_r, k_nxt};
            state_nxt   = S_PUSH;
          end
        end else begin
          k_nxt       = k_r + 1'b1;
          sym_rd_addr = {e_r, k_nxt};
        end
      end
      S_PUSH: begin
        // Push the right-hand side from its last symbol down to its first.
        if (sym_rd_data != EPSILON) begin
          stk_we    = 1'b1;
          stk_waddr = sp_r[STK_AW-1:0];
          stk_wdata = sym_rd_data;
          sp_nxt    = sp_r + 1'b1;
          top_nxt   = sym_rd_data;
        end
        if (k_r == '0) begin
          count_nxt = count_r + 1'b1;
          if (pushes_r == '0) begin
            ret_fin_nxt = 1'b0;
            state_nxt   = S_TOPRD;
          end else begin
            state_nxt = S_EXP;
          end
        end else begin
          k_nxt       = k_r - 1'b1;
          sym_rd_addr = {e_r, k_nxt};
        end
      end
      S_TOPRD: begin
        stk_raddr = STK_AW'(sp_r - 1'b1);
        state_nxt = S_TOPWT;
      end
      S_TOPWT: begin
        top_nxt = stk_rd_r;
        if (ret_fin_r) begin
          res_nxt   = '{ST_PARSING, count_r, sp_r};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EXP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A push never writes past the end of the stack.
  a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && stk_we) |-> sp_r < SP_W'(STACK_DEPTH))
    else $error("stack push beyond depth");

  // The expansion count never passes its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(EXP_LIMIT))
    else $error("expansion count beyond limit");

  // Before any begin the stack stays empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> sp_r == '0)
    else $error("stack not empty while idle");

  // A result is only loaded after a token or end of input was worked on.
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && $past(state_r) != S_DONE) |->
      ($past(state_r) == S_IDLE || $past(state_r) == S_EXP ||
       $past(state_r) == S_LEN || $past(state_r) == S_CNT ||
       $past(state_r) == S_TOPWT))
    else $error("unexpected path into result state");

endmodule

[test/ll1_predictive_parser_core_tb.sv]
// Self-checking testbench for the LL(1) predictive parser core.
`timescale 1ns / 1ps
module ll1_predictive_parser_core_tb;
  import llp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  ll1_predictive_parser_core uut (.*);

  // Shadow copy of the parser state and registers.
  logic [7:0] start_sym;
  int         nt_count;
  int         t_count;
  logic [7:0] nt_sym[NONTERMINALS];
  logic [7:0] t_sym[TERMINALS];
  logic [3:0] rhs_len[ENTRIES];
  logic [7:0] rhs_sym[ENTRIES*PROD_LEN];
  bit         rhs_known[ENTRIES*PROD_LEN];
  logic [7:0] stk[STACK_DEPTH];
  int         sp;
  phase_t     phase;

  out_item_t  verdicts[$];
  int         errors;
  int         items_sent;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int find_nt(logic [7:0] s);
    int n;
    n = (nt_count > NONTERMINALS) ? NONTERMINALS : nt_count;
    for (int i = 0; i < n; i++) if (nt_sym[i] == s) return i;
    return -1;
  endfunction

  function automatic int find_t(logic [7:0] s);
    int n;
    n = (t_count > TERMINALS) ? TERMINALS : t_count;
    for (int i = 0; i < n; i++) if (t_sym[i] == s) return i;
    return -1;
  endfunction

  // Expand nonterminals on top of the stack through one table column.
  function automatic bit expand_top(int col, output int cnt);
    int row, e, len, pushes;
    cnt = 0;
    while (sp > 1) begin
      row = find_nt(stk[sp-1]);
      if (row < 0) return 1;
      e = row * COLUMNS + col;
      len = int'(rhs_len[e]);
      if (len == 0) return 0;
      if (cnt >= EXP_LIMIT) return 0;
      pushes = 0;
      for (int k = 0; k < len; k++) if (rhs_sym[e*PROD_LEN+k] != EPSILON) pushes++;
      if (sp - 1 + pushes > STACK_DEPTH) return 0;
      sp--;
      for (int k = len; k > 0; k--) begin
        if (rhs_sym[e*PROD_LEN+k-1] != EPSILON) begin
          stk[sp] = rhs_sym[e*PROD_LEN+k-1];
          sp++;
        end
      end
      cnt++;
    end
    return 1;
  endfunction

  // Apply one accepted transaction to the shadow state; queue any verdict.
  function automatic void predict_parse(in_item_t it);
    int cnt, t, idx;
    bit ok;
    out_item_t r;
    cnt = 0;
    idx = (it.row_index * COLUMNS + it.col_index) * PROD_LEN + it.position;
    case (op_t'(it.operation))
      OP_NT_WR: begin
        nt_sym[it.row_index] = it.symbol;
        return;
      end
      OP_T_WR: begin
        if (it.col_index < TERMINALS) t_sym[it.col_index] = it.symbol;
        return;
      end
      OP_SYM_WR: begin
        if (it.col_index <= TERMINALS) begin
          rhs_sym[idx] = it.symbol;
          rhs_known[idx] = 1;
        end
        return;
      end
      OP_LEN_WR: begin
        if (it.col_index <= TERMINALS)
          rhs_len[it.row_index*COLUMNS+it.col_index] =
            LEN_W'((it.entry_length > PROD_LEN) ? PROD_LEN : it.entry_length);
        return;
      end
      OP_BEGIN: begin
        stk[0] = END_MARK;
        stk[1] = start_sym;
        sp = 2;
        phase = PH_PARSING;
        return;
      end
      OP_TOKEN, OP_EOI: ;
      default: return;
    endcase
    if (phase == PH_IDLE || phase == PH_REJECTED) r.status = ST_REJECT;
    else if (phase == PH_ACCEPTED) r.status = ST_ACCEPT;
    else if (op_t'(it.operation) == OP_TOKEN) begin
      t = find_t(it.symbol);
      ok = 0;
      if (t >= 0) begin
        if (expand_top(t, cnt) && sp > 1 && stk[sp-1] == it.symbol) begin
          sp--;
          ok = 1;
        end
      end
      r.status = ok ? ST_PARSING : ST_REJECT;
      if (!ok) phase = PH_REJECTED;
    end else begin
      ok = expand_top(TERMINALS, cnt) && sp == 1;
      r.status = ok ? ST_ACCEPT : ST_REJECT;
      phase = ok ? PH_ACCEPTED : PH_REJECTED;
    end
    r.expansions = cnt[CNT_W-1:0];
    r.stack_level = sp[SP_W-1:0];
    verdicts.push_back(r);
  endfunction

  function automatic in_item_t mk(op_t op, logic [7:0] s);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.symbol = s;
    return it;
  endfunction

  // Send one input transaction; before it the sender idles cycle by cycle.
  task automatic send_item(in_item_t it);
    bit rdy;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    predict_parse(it);
    items_sent++;
  endtask

  // Wait until every verdict has arrived and the core has gone quiet.
  task automatic drain;
    in_valid <= 0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    bit rdy;
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 0;
    case (idx)
      CFG_START:    start_sym = val;
      CFG_NT_COUNT: nt_count = int'(val[4:0]);
      CFG_T_COUNT:  t_count = int'(val[4:0]);
      default: ;
    endcase
  endtask

  task automatic set_grammar_cfg(logic [7:0] s, int ntc, int tc);
    write_reg(CFG_START, s);
    write_reg(CFG_NT_COUNT, ntc[7:0]);
    write_reg(CFG_T_COUNT, tc[7:0]);
  endtask

  // Load one table entry: its symbols first, then its length.
  task automatic load_entry(int row, int col, string rhs);
    in_item_t it;
    for (int k = 0; k < rhs.len(); k++) begin
      it = mk(OP_SYM_WR, rhs[k]);
      it.row_index = ROW_W'(row);
      it.col_index = COL_W'(col);
      it.position = POS_W'(k);
      send_item(it);
    end
    it = mk(OP_LEN_WR, 0);
    it.row_index = ROW_W'(row);
    it.col_index = COL_W'(col);
    it.entry_length = LEN_W'(rhs.len());
    send_item(it);
  endtask

  task automatic send_tokens(string toks, bit with_eoi);
    send_item(mk(OP_BEGIN, 0));
    for (int k = 0; k < toks.len(); k++) send_item(mk(OP_TOKEN, toks[k]));
    if (with_eoi) send_item(mk(OP_EOI, 0));
  endtask

  // Random expression sentences over + * ( ) i.
  function automatic void gen_factor(int d, int maxd, ref logic [7:0] q[$]);
    if (d < maxd && $urandom_range(2) == 0) begin
      q.push_back("(");
      gen_expr(d + 1, maxd, q);
      q.push_back(")");
    end else q.push_back("i");
  endfunction

  function automatic void gen_term(int d, int maxd, ref logic [7:0] q[$]);
    gen_factor(d, maxd, q);
    while ($urandom_range(2) == 0) begin
      q.push_back("*");
      gen_factor(d, maxd, q);
    end
  endfunction

  function automatic void gen_expr(int d, int maxd, ref logic [7:0] q[$]);
    gen_term(d, maxd, q);
    while ($urandom_range(2) == 0) begin
      q.push_back("+");
      gen_term(d, maxd, q);
    end
  endfunction

  // Parse one random sentence; some are corrupted, cut short or overrun.
  task automatic parse_sentence(int maxd);
    logic [7:0] q[$];
    int bad;
    gen_expr(0, maxd, q);
    bad = $urandom_range(99);
    if (bad < 10) q[$urandom_range(q.size()-1)] = 8'($urandom_range(255));
    else if (bad < 15) q[$urandom_range(q.size()-1)] = t_sym[$urandom_range(15)];
    else if (bad < 20 && q.size() > 1) q.delete($urandom_range(q.size()-1));
    send_item(mk(OP_BEGIN, 0));
    foreach (q[k]) send_item(mk(OP_TOKEN, q[k]));
    if (bad != 30) send_item(mk(OP_EOI, 0));
    if (bad > 90) send_item(mk($urandom_range(1) ? OP_TOKEN : OP_EOI, "i"));
  endtask

  // A random load or control transaction away from the expression grammar rows.
  task automatic send_noise;
    in_item_t it;
    int e, n;
    bit known;
    it.operation = 3'($urandom_range(7));
    it.row_index = ROW_W'($urandom_range(5, 15));
    it.col_index = COL_W'($urandom_range(5, 31));
    it.position = POS_W'($urandom_range(7));
    it.symbol = SYM_W'($urandom_range(255));
    it.entry_length = LEN_W'($urandom_range(15));
    // A length may only cover symbols that were written.
    if (op_t'(it.operation) == OP_LEN_WR && it.col_index <= TERMINALS) begin
      e = it.row_index * COLUMNS + it.col_index;
      n = (it.entry_length > PROD_LEN) ? PROD_LEN : it.entry_length;
      known = 1;
      for (int k = 0; k < n; k++) known &= rhs_known[e*PROD_LEN+k];
      if (!known) it.operation = OP_SYM_WR;
    end
    send_item(it);
  endtask

  // Parses before any begin, full list loads and the expression grammar.
  task automatic test_load_grammar;
    string nts, ts;
    in_item_t it;
    nts = "ETXYFABCGHJKLMNO";
    ts = "+*()iabcdefghjkl";
    send_item(mk(OP_TOKEN, "i"));
    send_item(mk(OP_EOI, 0));
    for (int k = 0; k < NONTERMINALS; k++) begin
      it = mk(OP_NT_WR, nts[k]);
      it.row_index = ROW_W'(k);
      send_item(it);
      it = mk(OP_T_WR, ts[k]);
      it.col_index = COL_W'(k);
      send_item(it);
    end
    // Terminal list write past the end is dropped.
    it = mk(OP_T_WR, 8'hFF);
    it.col_index = 5'd31;
    send_item(it);
    load_entry(0, 2, "TX");
    load_entry(0, 4, "TX");
    load_entry(2, 0, "+TX");
    load_entry(2, 3, "#");
    load_entry(2, 16, "#");
    load_entry(1, 2, "FY");
    load_entry(1, 4, "FY");
    load_entry(3, 1, "*FY");
    load_entry(3, 0, "#");
    load_entry(3, 3, "#");
    load_entry(3, 16, "#");
    load_entry(4, 2, "(E)");
    load_entry(4, 4, "i");
    load_entry(4, 1, "i");
    load_entry(4, 16, "i");
    // Helper rows for the limit and overflow cases.
    load_entry(5, 4, "B");
    load_entry(6, 4, "A");
    load_entry(7, 4, "CCCCCCCC");
    load_entry(8, 0, "abcdefgh");
    // Oversized length saturates; table write past the end column is dropped.
    it = mk(OP_LEN_WR, 0);
    it.row_index = 8;
    it.entry_length = 4'd15;
    send_item(it);
    it = mk(OP_SYM_WR, 8'hAA);
    it.row_index = 4'd15;
    it.col_index = 5'd31;
    it.position = 3'd7;
    send_item(it);
    send_item(mk(OP_NONE, 8'hFF));
    set_grammar_cfg("E", 16, 16);
  endtask

  // Accept, reject and verdict-hold cases on the expression grammar.
  task automatic test_parse_cases;
    send_tokens("i+i*(i)", 1);
    send_item(mk(OP_TOKEN, "i"));
    send_item(mk(OP_EOI, 0));
    send_tokens("z", 1);
    send_tokens("+", 0);
    send_tokens("i*", 0);
    send_item(mk(OP_TOKEN, "*"));
    send_tokens("i*", 1);
    send_tokens("i)", 0);
    send_item(mk(OP_TOKEN, "i"));
    send_item(mk(OP_EOI, 0));
    send_tokens("((((((((((((((((((((((i", 0);
  endtask

  // Expansion limit on a cycle of unit rules, overflow on a growing rule.
  task automatic test_limits;
    set_grammar_cfg("A", 16, 16);
    send_tokens("i", 0);
    write_reg(CFG_START, "C");
    send_tokens("i", 0);
    write_reg(CFG_START, "H");
    send_tokens("+", 1);
    set_grammar_cfg(8'h00, 0, 0);
    send_tokens("i", 1);
    set_grammar_cfg(8'hFF, 31, 31);
    send_tokens("i", 1);
    set_grammar_cfg("E", 16, 16);
  endtask

  // Receiver holds off while the sender keeps offering, then a full pause.
  task automatic test_backpressure;
    drain();
    hold_cycles = 400;
    repeat (4) parse_sentence(3);
    drain();
    repeat (3) parse_sentence(3);
  endtask

  task automatic test_random;
    int goal;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case (p)
        5: set_grammar_cfg("T", 5, 5);
        6: set_grammar_cfg("F", 17, 20);
        7: set_grammar_cfg("E", $urandom_range(5, 31), $urandom_range(5, 31));
        default: set_grammar_cfg("E", 16, 16);
      endcase
      goal = items_sent + 190;
      while (items_sent < goal) begin
        if ($urandom_range(9) == 0) send_noise();
        else parse_sentence($urandom_range(9) == 0 ? 12 : 4);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Result side: random stalls, long hold-offs and the in-order check.
  initial begin
    bit hs;
    out_item_t got, want;
    out_ready = 0;
    forever begin
      @(negedge clk);
      hs = out_valid && out_ready;
      got = out_data;
      @(posedge clk);
      if (hs) begin
        if (verdicts.size() == 0) begin
          $error("result with nothing pending: status %0d", got.status);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.expansions !== want.expansions) begin
            $error("expansions expected %0d actual %0d", want.expansions, got.expansions);
            errors++;
          end
          if (got.stack_level !== want.stack_level) begin
            $error("stack_level expected %0d actual %0d", want.stack_level,
                   got.stack_level);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = CFG_START;
    cfg_data = '0;
    start_sym = 8'd83;
    nt_count = 0;
    t_count = 0;
    sp = 0;
    phase = PH_IDLE;
    errors = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    foreach (rhs_len[i]) rhs_len[i] = '0;
    foreach (rhs_known[i]) rhs_known[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_load_grammar();
    test_parse_cases();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
